// ===== hw/rtl/imh_pkg.sv =====
package imh_pkg;

  localparam int HEAP_DEPTH_DEF  = 1024;
  localparam int MAX_HANDLES_DEF = 4096;
  localparam int VALUE_W         = 32;
  localparam int HANDLE_W        = 13;

  localparam logic [2:0] OP_INSERT  = 3'd0;
  localparam logic [2:0] OP_PEEK    = 3'd1;
  localparam logic [2:0] OP_DEL_MIN = 3'd2;
  localparam logic [2:0] OP_DEL_H   = 3'd3;
  localparam logic [2:0] OP_MOD_H   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [2:0]                opcode;
    logic [HANDLE_W-1:0]       handle;
    logic signed [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [1:0]                status;
  } out_item_t;

  // one strobe per controller step
  typedef struct packed {
    logic clr;
    logic load;
    logic disp;
    logic lk;
    logic lkc;
    logic rma;
    logic rmb;
    logic rmc;
    logic dl;
    logic dr;
    logic dc;
    logic ua;
    logic ub;
    logic place;
    logic rta;
    logic rtb;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic go_up;
    logic go_rm;
    logic go_lk;
    logic kbad;
    logic is_del;
    logic k_last;
    logic no_left;
    logic down_stop;
    logic at_root;
    logic up_stop;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/imh_ctrl.sv =====
module imh_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  imh_pkg::sts_t sts,
  output imh_pkg::cmd_t cmd
);

  typedef enum logic [16:0] {
    S_CLR   = 17'h00001,
    S_IDLE  = 17'h00002,
    S_DISP  = 17'h00004,
    S_LK    = 17'h00008,
    S_LKC   = 17'h00010,
    S_RMA   = 17'h00020,
    S_RMB   = 17'h00040,
    S_RMC   = 17'h00080,
    S_DL    = 17'h00100,
    S_DR    = 17'h00200,
    S_DC    = 17'h00400,
    S_UA    = 17'h00800,
    S_UB    = 17'h01000,
    S_PLACE = 17'h02000,
    S_RTA   = 17'h04000,
    S_RTB   = 17'h08000,
    S_FIN   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        cmd.disp = 1'b1;
        priority if (sts.go_up) state_nxt = S_UA;
        else if (sts.go_rm)     state_nxt = S_RMA;
        else if (sts.go_lk)     state_nxt = S_LK;
        else                    state_nxt = S_RTA;
      end
      S_LK: begin
        cmd.lk    = 1'b1;
        state_nxt = S_LKC;
      end
      S_LKC: begin
        cmd.lkc = 1'b1;
        priority if (sts.kbad) state_nxt = S_RTA;
        else if (sts.is_del)   state_nxt = S_RMA;
        else                   state_nxt = S_DL;
      end
      S_RMA: begin
        cmd.rma   = 1'b1;
        state_nxt = S_RMB;
      end
      S_RMB: begin
        cmd.rmb   = 1'b1;
        state_nxt = S_RMC;
      end
      S_RMC: begin
        cmd.rmc   = 1'b1;
        state_nxt = sts.k_last ? S_RTA : S_DL;
      end
      S_DL: begin
        cmd.dl    = 1'b1;
        state_nxt = sts.no_left ? S_UA : S_DR;
      end
      S_DR: begin
        cmd.dr    = 1'b1;
        state_nxt = S_DC;
      end
      S_DC: begin
        cmd.dc    = 1'b1;
        state_nxt = sts.down_stop ? S_UA : S_DL;
      end
      S_UA: begin
        cmd.ua    = 1'b1;
        state_nxt = sts.at_root ? S_PLACE : S_UB;
      end
      S_UB: begin
        cmd.ub    = 1'b1;
        state_nxt = sts.up_stop ? S_PLACE : S_UA;
      end
      S_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = S_RTA;
      end
      S_RTA: begin
        cmd.rta   = 1'b1;
        state_nxt = S_RTB;
      end
      S_RTB: begin
        cmd.rtb   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

endmodule

// ===== hw/rtl/imh_dp.sv =====
module imh_dp #(
  parameter int HEAP_DEPTH  = imh_pkg::HEAP_DEPTH_DEF,
  parameter int MAX_HANDLES = imh_pkg::MAX_HANDLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  imh_pkg::in_item_t  in_item,
  input  logic               out_stall,
  output logic               out_valid,
  output imh_pkg::out_item_t out_item,
  input  imh_pkg::cmd_t      cmd,
  output imh_pkg::sts_t      sts
);

  localparam int PW = $clog2(HEAP_DEPTH + 1);
  localparam int HW = $clog2(MAX_HANDLES);
  localparam int IW = $clog2(MAX_HANDLES + 1);
  localparam int VW = imh_pkg::VALUE_W;
  localparam int KW = imh_pkg::HANDLE_W;

  // heap entries by position (1-based) and position by handle
  logic signed [VW-1:0] val_mem [0:HEAP_DEPTH];
  logic [HW-1:0]        hdl_mem [0:HEAP_DEPTH];
  logic [PW-1:0]        hs_mem  [0:MAX_HANDLES-1];

  logic signed [VW-1:0] val_q;
  logic [HW-1:0]        hdl_q;
  logic [PW-1:0]        hs_q;

  logic [2:0]           op_r, op_nxt;
  logic [KW-1:0]        h_r, h_nxt;
  logic signed [VW-1:0] key_r, key_nxt;
  logic [HW-1:0]        mh_r, mh_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [PW-1:0]        cnt_r, cnt_nxt;
  logic [IW-1:0]        iss_r, iss_nxt;
  logic [1:0]           st_r, st_nxt;
  logic signed [VW-1:0] lv_r, lv_nxt;
  logic [HW-1:0]        lh_r, lh_nxt;
  logic                 re_r, re_nxt;
  logic signed [VW-1:0] min_r, min_nxt;
  logic [HW-1:0]        clr_r, clr_nxt;
  logic                 ov_r, ov_nxt;
  imh_pkg::out_item_t   od_r, od_nxt;

  logic [PW:0]          pos2, pos2p1, cnt_w;
  logic                 full, empty, hbad, kbad, pick_r;
  logic signed [VW-1:0] cv;
  logic [HW-1:0]        ch, hidx;
  logic [PW-1:0]        cp;

  logic                 s_we;
  logic [PW-1:0]        s_wa, s_ra;
  logic signed [VW-1:0] s_wv;
  logic [HW-1:0]        s_wh;
  logic                 h_we;
  logic [HW-1:0]        h_wa, h_ra;
  logic [PW-1:0]        h_wd;

  assign pos2   = {pos_r, 1'b0};
  assign pos2p1 = pos2 + {{PW{1'b0}}, 1'b1};
  assign cnt_w  = {1'b0, cnt_r};
  assign full   = (cnt_r == PW'(HEAP_DEPTH)) || (iss_r == IW'(MAX_HANDLES));
  assign empty  = (cnt_r == '0);
  assign hbad   = (h_r == '0) || (32'(h_r) > 32'(iss_r)) || (32'(h_r) > 32'(MAX_HANDLES));
  assign hidx   = HW'(32'(h_r) - 32'd1);
  assign kbad   = (hs_q == '0) || (hs_q > cnt_r);

  // smaller child; the right one wins only when strictly smaller
  assign pick_r = re_r && (lv_r > val_q);
  assign cv     = pick_r ? val_q : lv_r;
  assign ch     = pick_r ? hdl_q : lh_r;
  assign cp     = pick_r ? PW'(pos2p1) : PW'(pos2);

  always_comb begin
    sts           = '0;
    sts.clr_done  = (clr_r == HW'(MAX_HANDLES - 1));
    sts.go_up     = (op_r == imh_pkg::OP_INSERT) && !full;
    sts.go_rm     = (op_r == imh_pkg::OP_DEL_MIN) && !empty;
    sts.go_lk     = ((op_r == imh_pkg::OP_DEL_H) || (op_r == imh_pkg::OP_MOD_H)) && !hbad;
    sts.kbad      = kbad;
    sts.is_del    = (op_r == imh_pkg::OP_DEL_H);
    sts.k_last    = (pos_r == cnt_r);
    sts.no_left   = (pos2 > cnt_w);
    sts.down_stop = (key_r < cv);
    sts.at_root   = (pos_r == PW'(1));
    sts.up_stop   = (key_r >= val_q);
    sts.out_busy  = ov_r && out_stall;
  end

  // memory ports
  always_comb begin
    s_we = 1'b0;
    s_wa = pos_r;
    s_wv = key_r;
    s_wh = mh_r;
    s_ra = '0;
    h_we = 1'b0;
    h_wa = mh_r;
    h_wd = pos_r;
    h_ra = hidx;
    if (cmd.clr) begin
      h_we = 1'b1;
      h_wa = clr_r;
      h_wd = '0;
    end
    if (cmd.rma) s_ra = pos_r;
    if (cmd.rmb) begin
      s_ra = cnt_r;
      h_we = 1'b1;
      h_wa = hdl_q;
      h_wd = '0;
    end
    if (cmd.dl && !(pos2 > cnt_w)) s_ra = PW'(pos2);
    if (cmd.dr && (pos2p1 <= cnt_w)) s_ra = PW'(pos2p1);
    if (cmd.dc && !(key_r < cv)) begin
      s_we = 1'b1;
      s_wv = cv;
      s_wh = ch;
      h_we = 1'b1;
      h_wa = ch;
    end
    if (cmd.ua) s_ra = pos_r >> 1;
    if (cmd.ub && !(key_r >= val_q)) begin
      s_we = 1'b1;
      s_wv = val_q;
      s_wh = hdl_q;
      h_we = 1'b1;
      h_wa = hdl_q;
    end
    if (cmd.place) begin
      s_we = 1'b1;
      h_we = 1'b1;
    end
    if (cmd.rta) s_ra = PW'(1);
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      val_mem[s_wa] <= s_wv;
      hdl_mem[s_wa] <= s_wh;
    end
    val_q <= val_mem[s_ra];
    hdl_q <= hdl_mem[s_ra];
  end

  always_ff @(posedge clk) begin
    if (h_we) hs_mem[h_wa] <= h_wd;
    hs_q <= hs_mem[h_ra];
  end

  always_comb begin
    op_nxt  = op_r;
    h_nxt   = h_r;
    key_nxt = key_r;
    mh_nxt  = mh_r;
    pos_nxt = pos_r;
    cnt_nxt = cnt_r;
    iss_nxt = iss_r;
    st_nxt  = st_r;
    lv_nxt  = lv_r;
    lh_nxt  = lh_r;
    re_nxt  = re_r;
    min_nxt = min_r;
    clr_nxt = clr_r;
    ov_nxt  = ov_r && out_stall;
    od_nxt  = od_r;
    if (cmd.clr) clr_nxt = clr_r + HW'(1);
    if (cmd.load) begin
      op_nxt  = in_item.opcode;
      h_nxt   = in_item.handle;
      key_nxt = in_item.value;
    end
    if (cmd.disp) begin
      st_nxt = imh_pkg::ST_OK;
      priority case (op_r)
        imh_pkg::OP_INSERT: begin
          if (full) st_nxt = imh_pkg::ST_FULL;
          else begin
            cnt_nxt = cnt_r + PW'(1);
            pos_nxt = cnt_r + PW'(1);
            mh_nxt  = HW'(iss_r);
            iss_nxt = iss_r + IW'(1);
          end
        end
        imh_pkg::OP_DEL_MIN: begin
          if (empty) st_nxt = imh_pkg::ST_EMPTY;
          pos_nxt = PW'(1);
        end
        imh_pkg::OP_DEL_H, imh_pkg::OP_MOD_H: begin
          if (hbad) st_nxt = imh_pkg::ST_ABSENT;
        end
        default: begin
          if (empty) st_nxt = imh_pkg::ST_EMPTY;
        end
      endcase
    end
    if (cmd.lkc) begin
      if (kbad) st_nxt = imh_pkg::ST_ABSENT;
      pos_nxt = hs_q;
      mh_nxt  = hidx;
    end
    if (cmd.rmc) begin
      cnt_nxt = cnt_r - PW'(1);
      key_nxt = val_q;
      mh_nxt  = hdl_q;
    end
    if (cmd.dr) begin
      lv_nxt = val_q;
      lh_nxt = hdl_q;
      re_nxt = (pos2p1 <= cnt_w);
    end
    if (cmd.dc && !(key_r < cv)) pos_nxt = cp;
    if (cmd.ub && !(key_r >= val_q)) pos_nxt = pos_r >> 1;
    if (cmd.rtb) min_nxt = empty ? '0 : val_q;
    if (cmd.fin) begin
      ov_nxt           = 1'b1;
      od_nxt.min_value = min_r;
      od_nxt.status    = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      iss_r <= '0;
      clr_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      iss_r <= iss_nxt;
      clr_r <= clr_nxt;
      ov_r  <= ov_nxt;
    end
    op_r  <= op_nxt;
    h_r   <= h_nxt;
    key_r <= key_nxt;
    mh_r  <= mh_nxt;
    pos_r <= pos_nxt;
    st_r  <= st_nxt;
    lv_r  <= lv_nxt;
    lh_r  <= lh_nxt;
    re_r  <= re_nxt;
    min_r <= min_nxt;
    od_r  <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = od_r;

endmodule

// ===== hw/rtl/indexed_min_heap.sv =====
// Sequence: a peek or a rejected item goes from dispatch to the root read and the result;
//   a handle lookup, pulling the last entry into a removed slot, each level sifted down
//   and each level sifted up come between dispatch and the root read where the item needs them.
// Throughput: one item at a time; how long an item takes is set by the single read port
//   of the heap store that each sift level goes through.
// Reset: synchronous, active low; empties the heap, then clears the handle map in a
//   pass over every handle during which no item is taken.
module indexed_min_heap #(
  parameter int HEAP_DEPTH  = imh_pkg::HEAP_DEPTH_DEF,
  parameter int MAX_HANDLES = imh_pkg::MAX_HANDLES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  imh_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output imh_pkg::out_item_t out_item
);

  // The controller sequences one item: dispatch, optional handle lookup,
  // removal, a hole-based sift down then up (the moving entry stays in
  // registers and only its final slot is written), then a root read.
  // The result sits in an output register so the next item can start
  // while the previous result waits to be taken.
  imh_pkg::cmd_t cmd;
  imh_pkg::sts_t sts;

  imh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imh_dp #(
    .HEAP_DEPTH  (HEAP_DEPTH),
    .MAX_HANDLES (MAX_HANDLES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH   = imh_pkg::HEAP_DEPTH_DEF;
  localparam int HANDLES = imh_pkg::MAX_HANDLES_DEF;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  imh_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  imh_pkg::out_item_t out_item;

  indexed_min_heap u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // shadow heap: 1-based positions, handles kept as handle-1
  logic signed [31:0] hv_mirror [1:DEPTH];
  int unsigned        hs_mirror [1:DEPTH];
  int unsigned        pos_of_handle [0:HANDLES-1];
  int unsigned        entry_count;
  int unsigned        handles_given;

  imh_pkg::out_item_t results_due[$];
  int                 error_count;
  int                 result_count;
  bit                 hold_off;   // forces a long receiver stall
  bit                 sender_busy; // sender runs in bursts; off means no gaps

  task automatic swap_pos(input int unsigned a, input int unsigned b);
    int unsigned ha, hb;
    logic signed [31:0] t;
    ha = hs_mirror[a];
    hb = hs_mirror[b];
    pos_of_handle[ha] = b;
    pos_of_handle[hb] = a;
    hs_mirror[a] = hb;
    hs_mirror[b] = ha;
    t = hv_mirror[a];
    hv_mirror[a] = hv_mirror[b];
    hv_mirror[b] = t;
  endtask

  // equal child swaps on the way down, only strictly smaller moves up
  task automatic settle(input int unsigned p);
    int unsigned c, q;
    q = p;
    forever begin
      c = q * 2;
      if (c > entry_count) break;
      if (c + 1 <= entry_count && hv_mirror[c] > hv_mirror[c+1]) c++;
      if (hv_mirror[q] < hv_mirror[c]) break;
      swap_pos(q, c);
      q = c;
    end
    q = p;
    while (q > 1) begin
      if (hv_mirror[q] >= hv_mirror[q/2]) break;
      swap_pos(q/2, q);
      q = q / 2;
    end
  endtask

  task automatic drop_pos(input int unsigned k);
    int unsigned last;
    last = entry_count;
    pos_of_handle[hs_mirror[k]] = 0;
    if (k != last) begin
      hv_mirror[k] = hv_mirror[last];
      hs_mirror[k] = hs_mirror[last];
      pos_of_handle[hs_mirror[k]] = k;
    end
    entry_count = last - 1;
    if (k <= entry_count) settle(k);
  endtask

  function automatic int unsigned slot_for(input logic [12:0] h);
    if (h == 0 || h > handles_given || h > HANDLES) return 0;
    return pos_of_handle[h-1];
  endfunction

  task automatic predict_heap(input imh_pkg::in_item_t it);
    imh_pkg::out_item_t r;
    int unsigned        k;
    r.status = imh_pkg::ST_OK;
    case (it.opcode)
      imh_pkg::OP_INSERT: begin
        if (entry_count >= DEPTH || handles_given >= HANDLES) begin
          r.status = imh_pkg::ST_FULL;
        end else begin
          entry_count++;
          hv_mirror[entry_count] = it.value;
          hs_mirror[entry_count] = handles_given;
          pos_of_handle[handles_given] = entry_count;
          handles_given++;
          settle(entry_count);
        end
      end
      imh_pkg::OP_DEL_MIN: begin
        if (entry_count == 0) r.status = imh_pkg::ST_EMPTY;
        else drop_pos(1);
      end
      imh_pkg::OP_DEL_H, imh_pkg::OP_MOD_H: begin
        k = slot_for(it.handle);
        if (k == 0 || k > entry_count) begin
          r.status = imh_pkg::ST_ABSENT;
        end else if (it.opcode == imh_pkg::OP_DEL_H) begin
          drop_pos(k);
        end else begin
          hv_mirror[k] = it.value;
          settle(k);
        end
      end
      default: begin
        if (entry_count == 0) r.status = imh_pkg::ST_EMPTY;
      end
    endcase
    r.min_value = entry_count != 0 ? hv_mirror[1] : '0;
    results_due.push_back(r);
  endtask

  // offer one item, hold it until taken; gaps come from burst pacing
  task automatic send_item(input logic [2:0] op, input logic [12:0] h,
                           input logic signed [31:0] v);
    imh_pkg::in_item_t it;
    it.opcode = op;
    it.handle = h;
    it.value  = v;
    if (sender_busy && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_heap(it);
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] any_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 7)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // a live handle, else any plausible one
  function automatic logic [12:0] pick_handle();
    int unsigned k;
    if (entry_count != 0 && $urandom_range(0, 3) != 0) begin
      k = $urandom_range(1, entry_count);
      return hs_mirror[k] + 1;
    end
    return $urandom_range(0, handles_given + 2);
  endfunction

  task automatic test_directed();
    send_item(imh_pkg::OP_PEEK, 0, 0);                 // empty heap peek
    send_item(imh_pkg::OP_DEL_MIN, 0, 0);              // empty heap delete
    send_item(imh_pkg::OP_DEL_H, 1, 0);                // handle not yet issued
    send_item(imh_pkg::OP_MOD_H, 0, 5);                // handle zero
    send_item(imh_pkg::OP_INSERT, 0, 32'sh7fff_ffff);
    send_item(imh_pkg::OP_INSERT, 13'h1fff, 32'sh8000_0000);
    send_item(imh_pkg::OP_INSERT, 0, 7);
    send_item(imh_pkg::OP_INSERT, 0, 7);               // equal keys
    send_item(imh_pkg::OP_INSERT, 0, -1);
    send_item(imh_pkg::OP_MOD_H, 1, -9);               // decrease key
    send_item(imh_pkg::OP_MOD_H, 2, 32'sh7fff_ffff);   // increase key of root
    send_item(imh_pkg::OP_DEL_H, 5, 0);                // drop a position that is not the last
    send_item(imh_pkg::OP_DEL_H, 5, 0);                // already deleted
    send_item(imh_pkg::OP_MOD_H, 13'h1fff, 0);         // far out of range
    send_item(3'd5, 0, 0);
    send_item(3'd6, 0, 0);
    send_item(3'd7, 0, 0);
    send_item(imh_pkg::OP_DEL_MIN, 0, 0);
    send_item(imh_pkg::OP_DEL_H, 3, 0);
    send_item(imh_pkg::OP_DEL_MIN, 0, 0);
    send_item(imh_pkg::OP_DEL_MIN, 0, 0);
    send_item(imh_pkg::OP_DEL_MIN, 0, 0);              // empty again
  endtask

  // inserts are the most common op, with lookups; heap grows deep enough for long sifts
  task automatic test_random_mix(input int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45)      send_item(imh_pkg::OP_INSERT, $urandom, any_value());
      else if (r < 55) send_item(imh_pkg::OP_PEEK, $urandom, $urandom);
      else if (r < 68) send_item(imh_pkg::OP_DEL_MIN, $urandom, $urandom);
      else if (r < 80) send_item(imh_pkg::OP_DEL_H, pick_handle(), $urandom);
      else if (r < 97) send_item(imh_pkg::OP_MOD_H, pick_handle(), any_value());
      else             send_item($urandom_range(5, 7), $urandom, $urandom);
    end
  endtask

  // receiver parks for a long while; sender keeps offering until input stalls
  task automatic test_backpressure();
    hold_off = 1'b1;
    sender_busy = 1'b0;
    for (int i = 0; i < 12; i++) send_item(imh_pkg::OP_INSERT, $urandom, any_value());
    sender_busy = 1'b1;
    hold_off = 1'b0;
  endtask

  task automatic test_drain_empty();
    while (entry_count != 0) send_item(imh_pkg::OP_DEL_MIN, $urandom, $urandom);
    send_item(imh_pkg::OP_PEEK, 0, 0);
  endtask

  // receiver stall pattern: runs of stalls and clear stretches
  initial begin
    int cnt;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (cnt = 0; cnt < 400; cnt++) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (cnt > 0) begin
        cnt--;
      end else begin
        out_stall <= $urandom_range(0, 2) == 0;
        cnt = $urandom_range(0, 9) == 0 ? 60 : $urandom_range(0, 6);
      end
    end
  end

  // compare every taken result against the oldest prediction
  initial begin
    imh_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        result_count++;
        if (results_due.size() == 0) begin
          $display("%0t unexpected result: actual min %0d status %0d", $time,
                   out_item.min_value, out_item.status);
          error_count++;
        end else begin
          want = results_due.pop_front();
          if (out_item.min_value !== want.min_value) begin
            $display("%0t min_value: expected %0d actual %0d", $time,
                     want.min_value, out_item.min_value);
            error_count++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t status: expected %0d actual %0d", $time,
                     want.status, out_item.status);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_valid      = 1'b0;
    in_item       = '0;
    rst_n         = 1'b0;
    hold_off      = 1'b0;
    sender_busy   = 1'b1;
    error_count   = 0;
    result_count  = 0;
    entry_count   = 0;
    handles_given = 0;
    for (int i = 0; i < HANDLES; i++) pos_of_handle[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(300);
    test_backpressure();
    test_random_mix(500);
    test_drain_empty();
    test_random_mix(150);
    pause_input();

    while (results_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
